>>> hdl/bpfa_pkg.sv
// Shared types, constants and helpers of the bitmap page frame allocator.
// Depends on nothing; the files that use it refer to it by scoped names.

package bpfa_pkg;

    // Bitmap word geometry
    localparam int unsigned WORD_BITS   = 32;
    localparam int unsigned BIT_IDX_W   = 5;
    localparam logic [WORD_BITS-1:0] ALL_ONES = 32'hFFFF_FFFF;

    // Frame count register
    localparam int unsigned FRAME_COUNT_W = 16;
    localparam logic [FRAME_COUNT_W-1:0] FRAME_COUNT_RESET = 16'd32768;

    // Request kinds
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_ALLOC_WR,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_DONE
    } t_state;

    // Operation of the shared word unit
    typedef enum logic {
        OP_SET_LOWEST,
        OP_CLEAR_BIT
    } t_word_op;

    // Status of the word under test
    typedef struct packed {
        logic                 full;
        logic [BIT_IDX_W-1:0] lo_clear;
    } t_word_res;

    // Position of the lowest set bit, found by halving in five steps
    function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
        logic [WORD_BITS-1:0] x;
        logic [BIT_IDX_W-1:0] p;
        x = v;
        p = '0;
        if (x[15:0] == 16'd0) begin
            p[4] = 1'b1;
            x    = x >> 16;
        end
        if (x[7:0] == 8'd0) begin
            p[3] = 1'b1;
            x    = x >> 8;
        end
        if (x[3:0] == 4'd0) begin
            p[2] = 1'b1;
            x    = x >> 4;
        end
        if (x[1:0] == 2'd0) begin
            p[1] = 1'b1;
            x    = x >> 2;
        end
        if (x[0] == 1'b0) begin
            p[0] = 1'b1;
        end
        return p;
    endfunction

endpackage

>>> hdl/bpfa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.

module bpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/bpfa_word_unit.sv
// Shared word unit: tests a bitmap word for a free frame and sets or clears one bit.
// Depends on bpfa_pkg.

module bpfa_word_unit (
    input  logic [bpfa_pkg::WORD_BITS-1:0] i_word,
    input  bpfa_pkg::t_word_op             i_op,
    input  logic [bpfa_pkg::BIT_IDX_W-1:0] i_bit,
    output logic [bpfa_pkg::WORD_BITS-1:0] o_word,
    output bpfa_pkg::t_word_res            o_res
);

    logic [bpfa_pkg::BIT_IDX_W-1:0] lo_clear;
    logic [bpfa_pkg::BIT_IDX_W-1:0] pos;
    logic [bpfa_pkg::WORD_BITS-1:0] onehot;

    // Find the lowest free frame in the word
    assign lo_clear       = bpfa_pkg::lowest_set(~i_word);
    assign o_res.full     = (i_word == bpfa_pkg::ALL_ONES);
    assign o_res.lo_clear = lo_clear;

    // Set the lowest free bit, or clear the requested one
    assign pos    = (i_op == bpfa_pkg::OP_SET_LOWEST) ? lo_clear : i_bit;
    assign onehot = {{(bpfa_pkg::WORD_BITS-1){1'b0}}, 1'b1} << pos;

    always_comb begin
        case (i_op)
            bpfa_pkg::OP_SET_LOWEST: o_word = i_word | onehot;
            bpfa_pkg::OP_CLEAR_BIT:  o_word = i_word & ~onehot;
            default:                 o_word = i_word;
        endcase
    end

endmodule

>>> hdl/bitmap_page_frame_allocator_unit.sv
// Bitmap page frame allocator: a word-serial scan over a one-bit-per-frame bitmap held in RAM.
// After reset the bitmap RAM is initialised by a sweep that writes one word per cycle,
// during which no request is taken (frame_count writes are taken at any time); frames
// 0..RESERVED_FRAMES-1 come out used. One request is handled at a time. An allocate reads one
// bitmap word per cycle through the RAM read port and the shared word unit, from word 0 up to
// word W-1, W = floor(min(frame_count, MAX_FRAMES)/32), and sets the lowest free bit of the
// first word that has one; it fails at once when W is zero. A free is a read-modify-write of
// one word; a free out of range leaves the bitmap untouched. The result then waits in ST_DONE
// until the response register is free.
// Depends on bpfa_pkg, bpfa_ram and bpfa_word_unit.

module bitmap_page_frame_allocator_unit #(
    parameter int MAX_FRAMES      = 32768,
    parameter int PAGE_BYTES      = 4096,
    parameter int RESERVED_FRAMES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_req_valid,
    output logic        o_req_ready,
    input  logic        i_mode,
    input  logic [31:0] i_phys_addr,
    // response channel
    output logic        o_rsp_valid,
    input  logic        i_rsp_ready,
    output logic [31:0] o_frame_addr,
    output logic        o_out_of_memory,
    // frame count register
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [bpfa_pkg::FRAME_COUNT_W-1:0] i_cfg_frame_count
);

    localparam int WORD_COUNT = MAX_FRAMES / 32;
    localparam int AW         = $clog2(WORD_COUNT);
    localparam int WCNT_W     = AW + 1;
    localparam int LIM_W      = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W      = (LIM_W > bpfa_pkg::FRAME_COUNT_W) ? LIM_W
                                                                  : bpfa_pkg::FRAME_COUNT_W;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int RES_CAP    = (RESERVED_FRAMES > MAX_FRAMES) ? MAX_FRAMES : RESERVED_FRAMES;
    localparam int FULL_WORDS = RES_CAP / 32;
    localparam int PART_BITS  = RES_CAP % 32;
    localparam logic [31:0] PART_MASK = 32'((64'd1 << PART_BITS) - 64'd1);
    localparam logic [CMP_W-1:0]  MAX_LIM    = CMP_W'(MAX_FRAMES);
    localparam logic [AW-1:0]     LAST_WORD  = AW'(WORD_COUNT - 1);
    localparam logic [WCNT_W-1:0] FULL_CNT   = WCNT_W'(FULL_WORDS);
    localparam logic [26:0]       WORD_LIM   = 27'(WORD_COUNT);

    // Registers
    bpfa_pkg::t_state r_state, n_state;
    logic [bpfa_pkg::FRAME_COUNT_W-1:0] r_frame_count;
    logic [AW-1:0] r_init_addr, n_init_addr;
    logic [AW-1:0] r_scan_addr, n_scan_addr;
    logic          r_issue_done, n_issue_done;
    logic          r_rd_vld, n_rd_vld;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [AW-1:0] r_rw_addr, n_rw_addr;
    logic [bpfa_pkg::BIT_IDX_W-1:0] r_bit, n_bit;
    logic [31:0]   r_wr_word, n_wr_word;
    logic [31:0]   r_res_addr, n_res_addr;
    logic          r_res_oom, n_res_oom;
    logic          r_rsp_valid, n_rsp_valid;
    logic [31:0]   r_rsp_addr, n_rsp_addr;
    logic          r_rsp_oom, n_rsp_oom;

    // Derived limits
    logic [CMP_W-1:0]  fc_ext;
    logic [CMP_W-1:0]  limit;
    logic [CMP_W-1:0]  words_full;
    logic [WCNT_W-1:0] words;
    logic [WCNT_W-1:0] words_m1;
    logic [31:0]       free_frame;
    logic              free_in_range;
    logic [31:0]       alloc_frame;
    logic [31:0]       init_word;

    // RAM and word unit wiring
    logic                 ram_we;
    logic [AW-1:0]        ram_wa;
    logic [31:0]          ram_wd;
    logic                 ram_re;
    logic [AW-1:0]        ram_ra;
    logic [31:0]          ram_rd;
    bpfa_pkg::t_word_op   unit_op;
    logic [31:0]          unit_word;
    bpfa_pkg::t_word_res  unit_res;

    bpfa_ram #(
        .WIDTH (32),
        .DEPTH (WORD_COUNT)
    ) u_bitmap (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_wa),
        .i_wr_data (ram_wd),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_ra),
        .o_rd_data (ram_rd)
    );

    bpfa_word_unit u_word (
        .i_word (ram_rd),
        .i_op   (unit_op),
        .i_bit  (r_bit),
        .o_word (unit_word),
        .o_res  (unit_res)
    );

    // Clamp frame count and work out the number of searched words
    assign fc_ext     = CMP_W'(r_frame_count);
    assign limit      = (fc_ext > MAX_LIM) ? MAX_LIM : fc_ext;
    assign words_full = limit >> 5;
    assign words      = words_full[AW:0];
    assign words_m1   = words - WCNT_W'(1);

    // Frame named by a free request, and whether it lies in range
    assign free_frame    = 32'(i_phys_addr >> PAGE_SHIFT);
    assign free_in_range = (free_frame < 32'(limit)) && (free_frame[31:5] < WORD_LIM);

    // Byte address of the frame found by the scan
    assign alloc_frame = 32'({r_rd_idx, unit_res.lo_clear}) << PAGE_SHIFT;

    // Reset contents of the word being initialised
    always_comb begin
        if ({1'b0, r_init_addr} < FULL_CNT) begin
            init_word = bpfa_pkg::ALL_ONES;
        end else if (({1'b0, r_init_addr} == FULL_CNT) && (PART_BITS != 0)) begin
            init_word = PART_MASK;
        end else begin
            init_word = '0;
        end
    end

    assign o_req_ready     = (r_state == bpfa_pkg::ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_rsp_valid     = r_rsp_valid;
    assign o_frame_addr    = r_rsp_addr;
    assign o_out_of_memory = r_rsp_oom;

    // Sequencer: next state, RAM control and result staging
    always_comb begin
        n_state      = r_state;
        n_init_addr  = r_init_addr;
        n_scan_addr  = r_scan_addr;
        n_issue_done = r_issue_done;
        n_rd_vld     = r_rd_vld;
        n_rd_idx     = r_rd_idx;
        n_rw_addr    = r_rw_addr;
        n_bit        = r_bit;
        n_wr_word    = r_wr_word;
        n_res_addr   = r_res_addr;
        n_res_oom    = r_res_oom;
        n_rsp_valid  = r_rsp_valid;
        n_rsp_addr   = r_rsp_addr;
        n_rsp_oom    = r_rsp_oom;
        ram_we       = 1'b0;
        ram_wa       = r_rw_addr;
        ram_wd       = unit_word;
        ram_re       = 1'b0;
        ram_ra       = r_scan_addr;
        unit_op      = (r_state == bpfa_pkg::ST_FREE_WR) ? bpfa_pkg::OP_CLEAR_BIT
                                                         : bpfa_pkg::OP_SET_LOWEST;

        // drop a response once taken
        if (r_rsp_valid && i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end

        case (r_state)
            bpfa_pkg::ST_INIT: begin
                ram_we      = 1'b1;
                ram_wa      = r_init_addr;
                ram_wd      = init_word;
                n_init_addr = r_init_addr + AW'(1);
                if (r_init_addr == LAST_WORD) begin
                    n_state = bpfa_pkg::ST_IDLE;
                end
            end
            bpfa_pkg::ST_IDLE: begin
                if (i_req_valid) begin
                    n_res_addr = '0;
                    n_res_oom  = 1'b0;
                    if (i_mode == bpfa_pkg::MODE_ALLOC) begin
                        if (words == '0) begin
                            n_res_oom = 1'b1;
                            n_state   = bpfa_pkg::ST_DONE;
                        end else begin
                            n_scan_addr  = '0;
                            n_issue_done = 1'b0;
                            n_rd_vld     = 1'b0;
                            n_state      = bpfa_pkg::ST_SCAN;
                        end
                    end else if (free_in_range) begin
                        n_rw_addr = free_frame[AW+4:5];
                        n_bit     = free_frame[4:0];
                        n_state   = bpfa_pkg::ST_FREE_RD;
                    end else begin
                        n_state = bpfa_pkg::ST_DONE;
                    end
                end
            end
            bpfa_pkg::ST_SCAN: begin
                // issue one word read per cycle up to the last searched word
                ram_re   = !r_issue_done;
                ram_ra   = r_scan_addr;
                n_rd_vld = !r_issue_done;
                n_rd_idx = r_scan_addr;
                if (!r_issue_done) begin
                    if ({1'b0, r_scan_addr} == words_m1) begin
                        n_issue_done = 1'b1;
                    end else begin
                        n_scan_addr = r_scan_addr + AW'(1);
                    end
                end
                // test the word that has come back
                if (r_rd_vld) begin
                    if (!unit_res.full) begin
                        n_rw_addr  = r_rd_idx;
                        n_wr_word  = unit_word;
                        n_res_addr = alloc_frame;
                        n_state    = bpfa_pkg::ST_ALLOC_WR;
                    end else if ({1'b0, r_rd_idx} == words_m1) begin
                        n_res_oom = 1'b1;
                        n_state   = bpfa_pkg::ST_DONE;
                    end
                end
            end
            bpfa_pkg::ST_ALLOC_WR: begin
                ram_we  = 1'b1;
                ram_wa  = r_rw_addr;
                ram_wd  = r_wr_word;
                n_state = bpfa_pkg::ST_DONE;
            end
            bpfa_pkg::ST_FREE_RD: begin
                ram_re  = 1'b1;
                ram_ra  = r_rw_addr;
                n_state = bpfa_pkg::ST_FREE_WR;
            end
            bpfa_pkg::ST_FREE_WR: begin
                ram_we  = 1'b1;
                ram_wa  = r_rw_addr;
                ram_wd  = unit_word;
                n_state = bpfa_pkg::ST_DONE;
            end
            bpfa_pkg::ST_DONE: begin
                // hold until the response register is free
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_rsp_valid = 1'b1;
                    n_rsp_addr  = r_res_addr;
                    n_rsp_oom   = r_res_oom;
                    n_state     = bpfa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bpfa_pkg::ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= bpfa_pkg::ST_INIT;
            r_init_addr   <= '0;
            r_issue_done  <= 1'b0;
            r_rd_vld      <= 1'b0;
            r_rsp_valid   <= 1'b0;
            r_frame_count <= bpfa_pkg::FRAME_COUNT_RESET;
        end else begin
            r_state      <= n_state;
            r_init_addr  <= n_init_addr;
            r_issue_done <= n_issue_done;
            r_rd_vld     <= n_rd_vld;
            r_rsp_valid  <= n_rsp_valid;
            if (i_cfg_valid) begin
                r_frame_count <= i_cfg_frame_count;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_scan_addr <= n_scan_addr;
        r_rd_idx    <= n_rd_idx;
        r_rw_addr   <= n_rw_addr;
        r_bit       <= n_bit;
        r_wr_word   <= n_wr_word;
        r_res_addr  <= n_res_addr;
        r_res_oom   <= n_res_oom;
        r_rsp_addr  <= n_rsp_addr;
        r_rsp_oom   <= n_rsp_oom;
    end

endmodule
